// ----- design/pressure_zone_stability_monitor_defines.svh -----
// assertion macros shared by the monitor rtl
`ifndef PRESSURE_ZONE_STABILITY_MONITOR_DEFINES_SVH
`define PRESSURE_ZONE_STABILITY_MONITOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define PZSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pzsm: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define PZSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pzsm: next-cycle check failed");

`endif

// ----- design/pzsm_pkg.sv -----
// shared constants, codes and types of the pressure zone stability monitor
`timescale 1ns / 1ps
`default_nettype none

package pzsm_pkg;

  // field widths
  localparam int MV_W  = 12;
  localparam int PCT_W = 15;
  localparam int MIN_W = 23;
  localparam int SEC_W = 6;
  localparam int TCK_W = 32;

  // block constants
  localparam int WINDOW           = 10;
  localparam int TICKS_PER_SECOND = 10;
  localparam int SECS_PER_MIN     = 60;
  localparam int FULL_SCALE       = 25600;
  localparam int OPT_LOW          = 5632;
  localparam int OPT_HIGH         = 25574;
  localparam int STD_HIGH         = 1280;
  localparam int STD_MED          = 3840;
  localparam int FULL_LEVEL_RST   = 3300;

  // ring addressing
  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // sub-second tick counter
  localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

  // divider sizing: dividend is a 12 bit difference times full scale
  localparam int NUM_W = MV_W + PCT_W;
  localparam int CNT_W = $clog2(NUM_W);

  // window statistics sizing
  localparam longint unsigned WIN_L   = 64'(WINDOW);
  localparam longint unsigned FULL_SQ = 64'(FULL_SCALE) * 64'(FULL_SCALE);
  localparam int SUM_W  = $clog2(WINDOW * FULL_SCALE + 1);
  localparam int HSQ_W  = 2 * PCT_W;
  localparam int SQ_W   = $clog2(WIN_L * FULL_SQ + 64'd1);
  localparam int NQ_W   = $clog2(WIN_L * WIN_L * FULL_SQ + 64'd1);
  localparam longint unsigned TH_HIGH_L =
    WIN_L * WIN_L * 64'(STD_HIGH) * 64'(STD_HIGH);
  localparam longint unsigned TH_MED_L =
    WIN_L * WIN_L * 64'(STD_MED) * 64'(STD_MED);

  // configuration register indexes
  typedef enum logic {
    CFG_ZERO = 1'b0,
    CFG_FULL = 1'b1
  } cfg_reg_t;

  // zone codes
  typedef enum logic [1:0] {
    ZONE_LOW  = 2'd0,
    ZONE_OPT  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_t;

  // stability grades
  typedef enum logic [1:0] {
    STAB_HIGH = 2'd0,
    STAB_MED  = 2'd1,
    STAB_LOW  = 2'd2
  } stab_t;

  // top level sequencer
  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_PCT  = 4'b0010,
    T_WIN  = 4'b0100,
    T_HOLD = 4'b1000
  } top_state_t;

  // percent divider sequencer
  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_DIV  = 4'b0010,
    P_FIN  = 4'b0100,
    P_DONE = 4'b1000
  } pct_state_t;

  // window walker sequencer
  typedef enum logic [4:0] {
    W_IDLE = 5'b00001,
    W_READ = 5'b00010,
    W_ACC  = 5'b00100,
    W_MUL  = 5'b01000,
    W_CMP  = 5'b10000
  } win_state_t;

  // percent unit result
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
    logic             sat;
  } pct_rsp_t;

  // request into the window unit
  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic [PCT_W-1:0] data;
  } win_req_t;

  // window unit result
  typedef struct packed {
    logic  done;
    stab_t grade;
  } win_rsp_t;

endpackage

`default_nettype wire

// ----- design/pzsm_pct.sv -----
// percent scaling with a bit-serial restoring divider
`timescale 1ns / 1ps
`default_nettype none

module pzsm_pct (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pzsm_pkg::MV_W-1:0] sample,
  input  wire logic [pzsm_pkg::MV_W-1:0] zero_mv,
  input  wire logic [pzsm_pkg::MV_W-1:0] full_mv,
  output pzsm_pkg::pct_rsp_t             rsp
);

  pzsm_pkg::pct_state_t state_r, state_nxt;

  logic [pzsm_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [pzsm_pkg::MV_W-1:0]  den_r, den_nxt;
  logic [pzsm_pkg::MV_W-1:0]  rem_r, rem_nxt;
  logic [pzsm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pzsm_pkg::PCT_W-1:0] pct_r, pct_nxt;
  logic                       sat_r, sat_nxt;

  // signed differences, 13 bits hold the full span
  logic [pzsm_pkg::MV_W:0] d_diff;
  logic [pzsm_pkg::MV_W:0] r_diff;
  logic [pzsm_pkg::MV_W:0] trial;
  logic                    ge;

  assign d_diff = {1'b0, sample}  - {1'b0, zero_mv};
  assign r_diff = {1'b0, full_mv} - {1'b0, zero_mv};

  // one restoring step
  assign trial = {rem_r, num_r[pzsm_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // sequencer and datapath
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    pct_nxt   = pct_r;
    sat_nxt   = sat_r;
    unique case (state_r)
      pzsm_pkg::P_IDLE: begin
        if (start) begin
          if (d_diff[pzsm_pkg::MV_W] || (d_diff == '0) || r_diff[pzsm_pkg::MV_W]) begin
            // at or below zero level, or inverted range
            pct_nxt   = '0;
            sat_nxt   = 1'b0;
            state_nxt = pzsm_pkg::P_DONE;
          end else if (r_diff == '0) begin
            // empty range clamps to full scale
            pct_nxt   = pzsm_pkg::PCT_W'(pzsm_pkg::FULL_SCALE);
            sat_nxt   = 1'b1;
            state_nxt = pzsm_pkg::P_DONE;
          end else begin
            num_nxt   = pzsm_pkg::NUM_W'(d_diff[pzsm_pkg::MV_W-1:0]) *
                        pzsm_pkg::NUM_W'(pzsm_pkg::FULL_SCALE);
            den_nxt   = r_diff[pzsm_pkg::MV_W-1:0];
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = pzsm_pkg::P_DIV;
          end
        end
      end
      pzsm_pkg::P_DIV: begin
        rem_nxt = ge ? pzsm_pkg::MV_W'(trial - {1'b0, den_r}) : trial[pzsm_pkg::MV_W-1:0];
        num_nxt = {num_r[pzsm_pkg::NUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pzsm_pkg::CNT_W'(pzsm_pkg::NUM_W - 1)) begin
          state_nxt = pzsm_pkg::P_FIN;
        end
      end
      pzsm_pkg::P_FIN: begin
        // quotient now sits in num_r
        if (num_r > pzsm_pkg::NUM_W'(pzsm_pkg::FULL_SCALE)) begin
          pct_nxt = pzsm_pkg::PCT_W'(pzsm_pkg::FULL_SCALE);
          sat_nxt = 1'b1;
        end else begin
          pct_nxt = num_r[pzsm_pkg::PCT_W-1:0];
          sat_nxt = 1'b0;
        end
        state_nxt = pzsm_pkg::P_DONE;
      end
      pzsm_pkg::P_DONE: begin
        state_nxt = pzsm_pkg::P_IDLE;
      end
      default: begin
        state_nxt = pzsm_pkg::P_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pzsm_pkg::P_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    pct_r <= pct_nxt;
    sat_r <= sat_nxt;
  end

  assign rsp.done = (state_r == pzsm_pkg::P_DONE);
  assign rsp.pct  = pct_r;
  assign rsp.sat  = sat_r;

endmodule

`default_nettype wire

// ----- design/pzsm_window.sv -----
// history ring memory and window variance grading
`timescale 1ns / 1ps
`default_nettype none

module pzsm_window (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  pzsm_pkg::win_req_t      req,
  output pzsm_pkg::win_rsp_t      rsp
);

  // ring storage with a registered read
  logic [pzsm_pkg::PCT_W-1:0]  mem [pzsm_pkg::WINDOW];
  logic [pzsm_pkg::WINDOW-1:0] vld_r;
  logic [pzsm_pkg::ADDR_W-1:0] slot_r;

  pzsm_pkg::win_state_t state_r, state_nxt;

  logic [pzsm_pkg::ADDR_W-1:0] rd_idx_r;
  logic                        rd_en;
  logic [pzsm_pkg::PCT_W-1:0]  rd_data_r;
  logic                        rd_hit_r;
  logic                        rd_stb_r;
  logic [pzsm_pkg::PCT_W-1:0]  h_val;
  logic [pzsm_pkg::PCT_W-1:0]  h_r;
  logic [pzsm_pkg::HSQ_W-1:0]  hsq_r;
  logic                        sq_stb_r;
  logic [pzsm_pkg::SUM_W-1:0]  sum_r;
  logic [pzsm_pkg::SQ_W-1:0]   sq_acc_r;
  logic [2*pzsm_pkg::SUM_W-1:0] ssq_r;
  logic [pzsm_pkg::NQ_W-1:0]   nq_r;
  logic [pzsm_pkg::NQ_W-1:0]   spread;

  assign rd_en = (state_r == pzsm_pkg::W_READ);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[slot_r] <= req.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // valid bits stand in for the cleared contents after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      slot_r   <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[slot_r] <= 1'b1;
        if (slot_r == pzsm_pkg::ADDR_W'(pzsm_pkg::WINDOW - 1)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_idx_r];
      end
    end
  end

  assign h_val = rd_hit_r ? rd_data_r : '0;

  // walker sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pzsm_pkg::W_IDLE: if (req.start) state_nxt = pzsm_pkg::W_READ;
      pzsm_pkg::W_READ: begin
        if (rd_idx_r == pzsm_pkg::ADDR_W'(pzsm_pkg::WINDOW - 1)) begin
          state_nxt = pzsm_pkg::W_ACC;
        end
      end
      pzsm_pkg::W_ACC:  if (!rd_stb_r && !sq_stb_r) state_nxt = pzsm_pkg::W_MUL;
      pzsm_pkg::W_MUL:  state_nxt = pzsm_pkg::W_CMP;
      pzsm_pkg::W_CMP:  state_nxt = pzsm_pkg::W_IDLE;
      default:          state_nxt = pzsm_pkg::W_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pzsm_pkg::W_IDLE;
      rd_idx_r <= '0;
      rd_stb_r <= 1'b0;
      sq_stb_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_stb_r <= rd_en;
      sq_stb_r <= rd_stb_r;
      if (state_r == pzsm_pkg::W_IDLE) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // square stage, then accumulate sum and sum of squares
  always_ff @(posedge clk) begin
    if (rd_stb_r) begin
      h_r   <= h_val;
      hsq_r <= h_val * h_val;
    end
    if ((state_r == pzsm_pkg::W_IDLE) && req.start) begin
      sum_r    <= '0;
      sq_acc_r <= '0;
    end else if (sq_stb_r) begin
      sum_r    <= sum_r + pzsm_pkg::SUM_W'(h_r);
      sq_acc_r <= sq_acc_r + pzsm_pkg::SQ_W'(hsq_r);
    end
    if (state_r == pzsm_pkg::W_MUL) begin
      ssq_r <= sum_r * sum_r;
      nq_r  <= pzsm_pkg::NQ_W'(sq_acc_r) * pzsm_pkg::NQ_W'(pzsm_pkg::WINDOW);
    end
  end

  // n*q - s*s is never negative
  assign spread = nq_r - pzsm_pkg::NQ_W'(ssq_r);

  // grade against the scaled deviation limits
  always_comb begin
    if (spread < pzsm_pkg::NQ_W'(pzsm_pkg::TH_HIGH_L)) begin
      rsp.grade = pzsm_pkg::STAB_HIGH;
    end else if (spread < pzsm_pkg::NQ_W'(pzsm_pkg::TH_MED_L)) begin
      rsp.grade = pzsm_pkg::STAB_MED;
    end else begin
      rsp.grade = pzsm_pkg::STAB_LOW;
    end
  end

  assign rsp.done = (state_r == pzsm_pkg::W_CMP);

endmodule

`default_nettype wire

// ----- design/pressure_zone_stability_monitor.sv -----
// pressure zone stability monitor top level
// Usage:
//   Input channel in_*: one sensor sample per transfer (in_sample_mv, in_read_ok).
//   A transfer with in_read_ok low is dropped: no result, no state change.
//   Output channel out_*: one result per good sample, held in an output
//   register until taken; a finished result waits there while the next
//   sample is already accepted.
//   Config port cfg_*: index 0 zero level, index 1 full level; the user writes
//   it only while the block is idle, which the block itself does not enforce.
// Operation:
//   A sample that needs the divide is scaled to a percent (27 bit-serial divide
//   steps), then goes through 10 memory reads, square and accumulate stages,
//   then multiply and compare before the result turns valid. A sample at or
//   below the zero level, or with an empty or inverted range, skips the
//   divider. One sample is worked on at a time, so the next transfer is taken
//   no earlier than the cycle in which the result turns valid; a dropped
//   sample does not stall the input.
// Reset: synchronous, active low; history reads as zero, counters and ring
//   slot clear, zero level 0 mV, full level 3300 mV.
// Stall: while out_stall is high the result stays in the output register;
//   a newer result then waits inside and in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

`include "pressure_zone_stability_monitor_defines.svh"

module pressure_zone_stability_monitor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [pzsm_pkg::MV_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [pzsm_pkg::MV_W-1:0]  in_sample_mv,
  input  wire logic                       in_read_ok,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [pzsm_pkg::PCT_W-1:0]      out_pressure_pct,
  output logic                            out_saturated,
  output logic [1:0]                      out_zone,
  output logic [1:0]                      out_stability,
  output logic [pzsm_pkg::MIN_W-1:0]      out_minutes_in_zone,
  output logic [pzsm_pkg::SEC_W-1:0]      out_seconds_in_zone
);

  pzsm_pkg::top_state_t state_r, state_nxt;

  logic [pzsm_pkg::MV_W-1:0]  zero_mv_r;
  logic [pzsm_pkg::MV_W-1:0]  full_mv_r;

  logic [pzsm_pkg::TCK_W-1:0]  ticks_r, ticks_nxt;
  logic [pzsm_pkg::TICK_W-1:0] sub_r, sub_nxt;
  logic [pzsm_pkg::SEC_W-1:0]  secs_r, secs_nxt;
  logic [pzsm_pkg::MIN_W-1:0]  mins_r, mins_nxt;

  logic [pzsm_pkg::PCT_W-1:0] res_pct_r, res_pct_nxt;
  logic                       res_sat_r, res_sat_nxt;
  pzsm_pkg::zone_t            res_zone_r, res_zone_nxt;
  pzsm_pkg::stab_t            res_stab_r, res_stab_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;
  logic [pzsm_pkg::PCT_W-1:0] out_pct_r;
  logic                       out_sat_r;
  logic [1:0]                 out_zone_r;
  logic [1:0]                 out_stab_r;
  logic [pzsm_pkg::MIN_W-1:0] out_mins_r;
  logic [pzsm_pkg::SEC_W-1:0] out_secs_r;

  logic                  pct_start;
  pzsm_pkg::pct_rsp_t    pct_rsp;
  pzsm_pkg::win_req_t    win_req;
  pzsm_pkg::win_rsp_t    win_rsp;
  pzsm_pkg::zone_t       zone_now;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_mv_r <= '0;
      full_mv_r <= pzsm_pkg::MV_W'(pzsm_pkg::FULL_LEVEL_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pzsm_pkg::CFG_ZERO: zero_mv_r <= cfg_wdata;
        pzsm_pkg::CFG_FULL: full_mv_r <= cfg_wdata;
        default:            zero_mv_r <= zero_mv_r;
      endcase
    end
  end

  assign in_stall  = (state_r != pzsm_pkg::T_IDLE);
  assign pct_start = in_valid && !in_stall && in_read_ok;

  pzsm_pct u_pct (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pct_start),
    .sample  (in_sample_mv),
    .zero_mv (zero_mv_r),
    .full_mv (full_mv_r),
    .rsp     (pct_rsp)
  );

  pzsm_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .rsp   (win_rsp)
  );

  // zone of the fresh percent
  always_comb begin
    if (pct_rsp.pct < pzsm_pkg::PCT_W'(pzsm_pkg::OPT_LOW)) begin
      zone_now = pzsm_pkg::ZONE_LOW;
    end else if (pct_rsp.pct <= pzsm_pkg::PCT_W'(pzsm_pkg::OPT_HIGH)) begin
      zone_now = pzsm_pkg::ZONE_OPT;
    end else begin
      zone_now = pzsm_pkg::ZONE_HIGH;
    end
  end

  assign out_load = (state_r == pzsm_pkg::T_HOLD) && (!out_valid_r || !out_stall);

  // sequencer, time-in-zone counters and result capture
  always_comb begin
    state_nxt     = state_r;
    ticks_nxt     = ticks_r;
    sub_nxt       = sub_r;
    secs_nxt      = secs_r;
    mins_nxt      = mins_r;
    res_pct_nxt   = res_pct_r;
    res_sat_nxt   = res_sat_r;
    res_zone_nxt  = res_zone_r;
    res_stab_nxt  = res_stab_r;
    win_req.wr_en = 1'b0;
    win_req.start = 1'b0;
    win_req.data  = pct_rsp.pct;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      pzsm_pkg::T_IDLE: begin
        if (pct_start) state_nxt = pzsm_pkg::T_PCT;
      end
      pzsm_pkg::T_PCT: begin
        if (pct_rsp.done) begin
          win_req.wr_en = 1'b1;
          win_req.start = 1'b1;
          res_pct_nxt   = pct_rsp.pct;
          res_sat_nxt   = pct_rsp.sat;
          res_zone_nxt  = zone_now;
          // saturating tick count, kept also as minutes, seconds, sub-ticks
          if ((zone_now == pzsm_pkg::ZONE_OPT) && (ticks_r != '1)) begin
            ticks_nxt = ticks_r + 1'b1;
            if (sub_r == pzsm_pkg::TICK_W'(pzsm_pkg::TICKS_PER_SECOND - 1)) begin
              sub_nxt = '0;
              if (secs_r == pzsm_pkg::SEC_W'(pzsm_pkg::SECS_PER_MIN - 1)) begin
                secs_nxt = '0;
                mins_nxt = mins_r + 1'b1;
              end else begin
                secs_nxt = secs_r + 1'b1;
              end
            end else begin
              sub_nxt = sub_r + 1'b1;
            end
          end
          state_nxt = pzsm_pkg::T_WIN;
        end
      end
      pzsm_pkg::T_WIN: begin
        if (win_rsp.done) begin
          res_stab_nxt = win_rsp.grade;
          state_nxt    = pzsm_pkg::T_HOLD;
        end
      end
      pzsm_pkg::T_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pzsm_pkg::T_IDLE;
        end
      end
      default: begin
        state_nxt = pzsm_pkg::T_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pzsm_pkg::T_IDLE;
      ticks_r     <= '0;
      sub_r       <= '0;
      secs_r      <= '0;
      mins_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ticks_r     <= ticks_nxt;
      sub_r       <= sub_nxt;
      secs_r      <= secs_nxt;
      mins_r      <= mins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result and output payload registers
  always_ff @(posedge clk) begin
    res_pct_r  <= res_pct_nxt;
    res_sat_r  <= res_sat_nxt;
    res_zone_r <= res_zone_nxt;
    res_stab_r <= res_stab_nxt;
    if (out_load) begin
      out_pct_r  <= res_pct_r;
      out_sat_r  <= res_sat_r;
      out_zone_r <= res_zone_r;
      out_stab_r <= res_stab_r;
      out_mins_r <= mins_r;
      out_secs_r <= secs_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pressure_pct    = out_pct_r;
  assign out_saturated       = out_sat_r;
  assign out_zone            = out_zone_r;
  assign out_stability       = out_stab_r;
  assign out_minutes_in_zone = out_mins_r;
  assign out_seconds_in_zone = out_secs_r;

  // checks on the sequencing between the units
  `PZSM_ASSERT_NOW(a_pct_done_in_pct, pct_rsp.done, state_r == pzsm_pkg::T_PCT)
  `PZSM_ASSERT_NOW(a_win_done_in_win, win_rsp.done, state_r == pzsm_pkg::T_WIN)
  `PZSM_ASSERT_NEXT(a_hold_to_out, out_load, out_valid_r && (state_r == pzsm_pkg::T_IDLE))
  `PZSM_ASSERT_NEXT(a_ticks_stick, ticks_r == '1, ticks_r == '1)

endmodule

`default_nettype wire
